// ----- rtl/dtbt_pkg.sv -----
// Shared types, register indexes and helper functions for the dirty tile band tracker.
// Used by dtbt_ctrl, dtbt_dp and dirty_tile_band_tracker; depends on nothing else.
`default_nettype none

package dtbt_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PIXEL_BYTES   = 2'd2;

   // Item functions.
   localparam logic FUNC_COMPARE = 1'b0;
   localparam logic FUNC_EMIT    = 1'b1;

   // Register reset values.
   localparam logic [11:0] SCREEN_WIDTH_RESET  = 12'd2048;
   localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd2048;
   localparam logic [2:0]  PIXEL_BYTES_RESET   = 3'd4;

   // Input item.
   typedef struct packed {
      logic        func;
      logic [10:0] pixel_x;
      logic [10:0] pixel_y;
      logic [31:0] old_pixel;
      logic [31:0] new_pixel;
      logic [5:0]  tile_row;
   } req_type;

   // Result item.
   typedef struct packed {
      logic        tile_changed;
      logic        band_valid;
      logic [10:0] band_x;
      logic [10:0] band_y;
      logic [11:0] band_w;
      logic [5:0]  band_h;
      logic [6:0]  tiles_in_band;
      logic        last;
   } rsp_type;

   // Effective configuration after clamping, handed to the datapath.
   typedef struct packed {
      logic [11:0] width;
      logic [11:0] height;
      logic [6:0]  width_tiles;
      logic [7:0]  height_tiles;
      logic [31:0] byte_mask;
   } cfg_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic cap;
      logic cmp_commit;
      logic row_clear;
      logic emit_empty;
      logic walk_load;
      logic walk_step;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic out_free;
      logic row_empty;
      logic band_due;
      logic walk_done;
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_LOAD,
      ST_WALK
   } state_type;

   // Mask of the low bytes that take part in a pixel compare.
   function automatic logic [31:0] byte_mask(input logic [2:0] nbytes);
      logic [31:0] m;
      begin
         case (nbytes)
            3'd0: m = 32'h0000_0000;
            3'd1: m = 32'h0000_00FF;
            3'd2: m = 32'h0000_FFFF;
            3'd3: m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
         endcase
         return m;
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/dtbt_ctrl.sv -----
// Controller state machine of the dirty tile band tracker.
// Depends on dtbt_pkg; drives the commands of dtbt_dp from its status.
`default_nettype none

module dtbt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_func,
   output logic                       req_ready,
   input  wire dtbt_pkg::status_type  status,
   output dtbt_pkg::cmd_type          cmd
);

   dtbt_pkg::state_type state_ff;
   dtbt_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtbt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtbt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_func == dtbt_pkg::FUNC_EMIT) ? dtbt_pkg::ST_LOAD
                                                             : dtbt_pkg::ST_CMP;
            end
         end
         dtbt_pkg::ST_CMP: begin
            if (status.out_free) begin
               state_in = dtbt_pkg::ST_IDLE;
            end
         end
         dtbt_pkg::ST_LOAD: begin
            if (!status.row_empty) begin
               state_in = dtbt_pkg::ST_WALK;
            end else if (status.out_free) begin
               state_in = dtbt_pkg::ST_IDLE;
            end
         end
         dtbt_pkg::ST_WALK: begin
            if (status.walk_done) begin
               state_in = dtbt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dtbt_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         dtbt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.cap   = req_valid;
         end
         dtbt_pkg::ST_CMP: begin
            cmd.cmp_commit = status.out_free;
         end
         dtbt_pkg::ST_LOAD: begin
            cmd.row_clear = 1'b1;
            if (status.row_empty) begin
               cmd.emit_empty = status.out_free;
            end else begin
               cmd.walk_load = 1'b1;
            end
         end
         dtbt_pkg::ST_WALK: begin
            // A step that closes a band waits until the result register is free.
            cmd.walk_step = !status.walk_done && (!status.band_due || status.out_free);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/dtbt_dp.sv -----
// Datapath of the dirty tile band tracker: tile flag memory, compare logic,
// row walker and result register. Depends on dtbt_pkg; commanded by dtbt_ctrl.
`default_nettype none

module dtbt_dp #(
   parameter int MAX_WIDTH_TILES  = 64,
   parameter int MAX_HEIGHT_TILES = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dtbt_pkg::cfg_type     cfg,
   input  wire dtbt_pkg::req_type     req_data,
   input  wire dtbt_pkg::cmd_type     cmd,
   output dtbt_pkg::status_type       status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output dtbt_pkg::rsp_type          rsp_data
);

   localparam int ROW_W = (MAX_HEIGHT_TILES > 1) ? $clog2(MAX_HEIGHT_TILES) : 1;
   localparam int MW    = MAX_WIDTH_TILES;

   // Tile flag memory; a row whose valid bit is low reads as all zero.
   logic [MW-1:0]               flag_mem [MAX_HEIGHT_TILES];
   logic [MAX_HEIGHT_TILES-1:0] row_vld_ff;
   logic [MAX_HEIGHT_TILES-1:0] row_vld_in;
   logic [MW-1:0]               rd_row_ff;
   logic                        rd_vld_ff;

   // Captured item.
   logic        func_ff;
   logic [10:0] px_ff;
   logic [10:0] py_ff;
   logic        diff_ff;
   logic [5:0]  row_ff;

   // Row walker.
   logic [MW-1:0] flags_ff;
   logic [MW-1:0] flags_in;
   logic [6:0]    col_ff;
   logic [6:0]    col_in;
   logic          run_ff;
   logic          run_in;
   logic [5:0]    start_ff;
   logic [5:0]    start_in;
   logic [6:0]    cnt_ff;
   logic [6:0]    cnt_in;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   dtbt_pkg::rsp_type rsp_ff;
   dtbt_pkg::rsp_type rsp_in;

   logic [5:0]      row_sel;
   logic [ROW_W-1:0] addr_sel;
   logic [ROW_W-1:0] addr_ff;
   logic            row_exists;
   logic [MW-1:0]   row_data;
   logic            on_screen;
   logic [5:0]      tx;
   logic [MW-1:0]   one_hot;
   logic [MW-1:0]   new_row;
   logic [MW-1:0]   tested_row;
   logic            chg;
   logic            on_row;
   logic [MW-1:0]   col_mask;
   logic [MW-1:0]   flags_load;
   logic [10:0]     band_y;
   logic [11:0]     height_rem;
   logic [5:0]      band_h;
   logic [10:0]     band_x;
   logic [11:0]     width_full;
   logic [11:0]     width_rem;
   logic [11:0]     band_w;
   logic            band_due;
   logic            out_free;
   logic            emit;

   // Row that an item touches, and its memory address.
   assign row_sel    = (req_data.func == dtbt_pkg::FUNC_EMIT) ? req_data.tile_row
                                                              : req_data.pixel_y[10:5];
   assign addr_sel   = ROW_W'(row_sel);
   assign addr_ff    = ROW_W'(row_ff);
   assign row_exists = 32'(row_ff) < 32'(MAX_HEIGHT_TILES);
   assign row_data   = rd_vld_ff ? rd_row_ff : '0;

   // Capture the item and read its row.
   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         func_ff   <= req_data.func;
         px_ff     <= req_data.pixel_x;
         py_ff     <= req_data.pixel_y;
         diff_ff   <= |((req_data.old_pixel ^ req_data.new_pixel) & cfg.byte_mask);
         row_ff    <= row_sel;
         rd_row_ff <= flag_mem[addr_sel];
         rd_vld_ff <= row_vld_ff[addr_sel];
      end
   end

   // Compare: merge the tile bit into the row read back.
   assign on_screen = ({1'b0, px_ff} < cfg.width) && ({1'b0, py_ff} < cfg.height);
   assign tx        = px_ff[10:5];

   always_comb begin
      one_hot    = '0;
      one_hot[0] = 1'b1;
   end

   assign new_row    = row_data | (diff_ff ? (one_hot << tx) : '0);
   assign tested_row = new_row >> tx;
   assign chg        = on_screen && tested_row[0];

   // Memory write-back of a compare.
   always_ff @(posedge clock) begin
      if (cmd.cmp_commit && on_screen) begin
         flag_mem[addr_ff] <= new_row;
      end
   end

   // Row valid bits: set by a compare write-back, cleared by an emit.
   always_comb begin
      row_vld_in = row_vld_ff;
      if (cmd.cmp_commit && on_screen) begin
         row_vld_in[addr_ff] = 1'b1;
      end else if (cmd.row_clear && row_exists) begin
         row_vld_in[addr_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else begin
         row_vld_ff <= row_vld_in;
      end
   end

   // Emit: keep only the columns inside the screen width, and no flags for a row below the screen.
   assign on_row = {2'b00, row_ff} < cfg.height_tiles;

   always_comb begin
      for (int i = 0; i < MW; i++) begin
         col_mask[i] = 7'(i) < cfg.width_tiles;
      end
   end

   assign flags_load = (on_row ? row_data : '0) & col_mask;

   // Vertical extent of the bands in this row, clipped to the screen height.
   assign band_y     = {row_ff, 5'b00000};
   assign height_rem = cfg.height - {1'b0, band_y};
   assign band_h     = (height_rem > 12'd32) ? 6'd32 : height_rem[5:0];

   // Walker: one tile column per step, a band closes on the first clear bit.
   assign band_due = run_ff && !flags_ff[0];

   always_comb begin
      flags_in = flags_ff;
      col_in   = col_ff;
      run_in   = run_ff;
      start_in = start_ff;
      cnt_in   = cnt_ff;
      if (cmd.walk_load) begin
         flags_in = flags_load;
         col_in   = '0;
         run_in   = 1'b0;
         start_in = '0;
         cnt_in   = '0;
      end else if (cmd.walk_step) begin
         flags_in = flags_ff >> 1;
         col_in   = col_ff + 7'd1;
         if (flags_ff[0]) begin
            if (run_ff) begin
               cnt_in = cnt_ff + 7'd1;
            end else begin
               run_in   = 1'b1;
               start_in = col_ff[5:0];
               cnt_in   = 7'd1;
            end
         end else begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
      col_ff   <= col_in;
      start_ff <= start_in;
      cnt_ff   <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   // Horizontal extent of the closing band, clipped to the screen width.
   assign band_x     = {start_ff, 5'b00000};
   assign width_full = {cnt_ff[6:0], 5'b00000};
   assign width_rem  = cfg.width - {1'b0, band_x};
   assign band_w     = (width_full > width_rem) ? width_rem : width_full;

   // Result register.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = cmd.cmp_commit || cmd.emit_empty || (cmd.walk_step && band_due);

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.cmp_commit) begin
         rsp_in              = '0;
         rsp_in.tile_changed = chg;
         rsp_in.last         = 1'b1;
      end else if (cmd.emit_empty) begin
         rsp_in      = '0;
         rsp_in.last = 1'b1;
      end else if (cmd.walk_step && band_due) begin
         rsp_in.tile_changed  = 1'b0;
         rsp_in.band_valid    = 1'b1;
         rsp_in.band_x        = band_x;
         rsp_in.band_y        = band_y;
         rsp_in.band_w        = band_w;
         rsp_in.band_h        = band_h;
         rsp_in.tiles_in_band = cnt_ff;
         rsp_in.last          = (flags_ff == '0);
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status to the controller.
   always_comb begin
      status           = '0;
      status.out_free  = out_free;
      status.row_empty = (flags_load == '0) || (func_ff != dtbt_pkg::FUNC_EMIT);
      status.band_due  = band_due;
      status.walk_done = !run_ff && (flags_ff == '0);
   end

endmodule

`default_nettype wire

// ----- rtl/dirty_tile_band_tracker.sv -----
// Dirty tile band tracker: holds the screen registers and the clamped view of them,
// and joins the controller (dtbt_ctrl) and the datapath (dtbt_dp). Depends on dtbt_pkg.
//
// The block keeps one changed flag per 32x32 pixel tile. A compare item (func 0)
// marks the tile of its pixel when the low pixel_bytes bytes of old and new value
// differ, and returns one result with the tile's flag; the flag memory row is read
// when the item is taken and written back with the result. An emit item (func 1)
// reads its tile row, clears it, and walks it one tile column per cycle from the
// left, giving one band result per run of changed tiles (last on the final one) or
// a single empty result. The walk ends after the rightmost changed tile. Items are
// handled one at a time, and a full result register stalls the walk.
// The flag memory has one valid bit per row, so no clearing pass is needed after reset.
`default_nettype none

module dirty_tile_band_tracker #(
   parameter int MAX_WIDTH_TILES  = 64,
   parameter int MAX_HEIGHT_TILES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire dtbt_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output dtbt_pkg::rsp_type       rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [11:0]        csr_wdata
);

   localparam logic [13:0] WIDTH_LIMIT  = 14'(MAX_WIDTH_TILES * 32);
   localparam logic [13:0] HEIGHT_LIMIT = 14'(MAX_HEIGHT_TILES * 32);

   logic [11:0] width_ff;
   logic [11:0] height_ff;
   logic [2:0]  pbytes_ff;
   logic [11:0] eff_width;
   logic [11:0] eff_height;
   logic [12:0] width_round;
   logic [12:0] height_round;

   dtbt_pkg::cfg_type    cfg;
   dtbt_pkg::cmd_type    cmd;
   dtbt_pkg::status_type status;

   // Configuration registers; writes to an unknown index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= dtbt_pkg::SCREEN_WIDTH_RESET;
         height_ff <= dtbt_pkg::SCREEN_HEIGHT_RESET;
         pbytes_ff <= dtbt_pkg::PIXEL_BYTES_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            dtbt_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            dtbt_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            dtbt_pkg::CSR_PIXEL_BYTES:   pbytes_ff <= csr_wdata[2:0];
            default: begin
               width_ff <= width_ff;
            end
         endcase
      end
   end

   // Clamp the screen size to the tile grid and round it up to whole tiles.
   assign eff_width    = ({2'b00, width_ff} > WIDTH_LIMIT) ? WIDTH_LIMIT[11:0] : width_ff;
   assign eff_height   = ({2'b00, height_ff} > HEIGHT_LIMIT) ? HEIGHT_LIMIT[11:0]
                                                              : height_ff;
   assign width_round  = {1'b0, eff_width} + 13'd31;
   assign height_round = {1'b0, eff_height} + 13'd31;

   always_comb begin
      cfg              = '0;
      cfg.width        = eff_width;
      cfg.height       = eff_height;
      cfg.width_tiles  = width_round[11:5];
      cfg.height_tiles = height_round[12:5];
      cfg.byte_mask    = dtbt_pkg::byte_mask(pbytes_ff);
   end

   dtbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dtbt_dp #(
      .MAX_WIDTH_TILES  (MAX_WIDTH_TILES),
      .MAX_HEIGHT_TILES (MAX_HEIGHT_TILES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
